/* hw/rtl/multi_timer_scheduler_defines.svh */
// Assertion macros shared by the timer scheduler checkers.
`ifndef MULTI_TIMER_SCHEDULER_DEFINES_SVH
`define MULTI_TIMER_SCHEDULER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int IDX_W      = $clog2(MAX_TIMERS);
  localparam int TIME_W     = 48;
  localparam int ID_W       = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_FULL  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] delay_ms;
    logic [31:0] interval_ms;
    logic [31:0] cancel_id;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] timer_id;
    logic [31:0] fire_count;
    logic        last;
  } out_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic due_lt;
    logic due_eq;
    logic key_lt;
  } cmp_res_t;

endpackage

`default_nettype wire

/* hw/rtl/mts_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none

module mts_cmp (
  input  wire logic [mts_pkg::TIME_W-1:0] a_due,
  input  wire logic [mts_pkg::ID_W-1:0]   a_id,
  input  wire logic [mts_pkg::TIME_W-1:0] b_due,
  input  wire logic [mts_pkg::ID_W-1:0]   b_id,
  output mts_pkg::cmp_res_t               res
);
  import mts_pkg::*;

  // One wide due compare serves both the due test and the ordering key.
  always_comb begin
    res.due_lt = (a_due < b_due);
    res.due_eq = (a_due == b_due);
    res.key_lt = res.due_lt || (res.due_eq && (a_id < b_id));
  end

endmodule

`default_nettype wire

/* hw/rtl/multi_timer_scheduler.sv */
// Add and clear each pass through their own state once; cancel walks the table up to a match or its end.
// Tick: a due scan of all entries, then a search pass and an emit for each fired timer, since
// one comparator walks the table one entry per cycle; with nothing due, one search pass
// follows the scan and no result is given.
// One transaction is processed at a time; in_ready is high only while idle.
// Reset (synchronous, active low) clears time, all entry valid bits and sets the next id to 1.
`timescale 1ns / 1ps
`default_nettype none

module multi_timer_scheduler (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mts_pkg::in_t    in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output mts_pkg::out_t        out_data
);
  import mts_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ADD    = 7'b0000010,
    S_CANCEL = 7'b0000100,
    S_CLEAR  = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_FIND   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TIMERS - 1);

  state_t                  state_r, state_nxt;
  in_t                     req_r, req_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic [ID_W-1:0]         nid_r, nid_nxt;
  logic [MAX_TIMERS-1:0]   valid_r, valid_nxt;
  logic [MAX_TIMERS-1:0]   pend_r, pend_nxt;
  logic                    found_r, found_nxt;
  logic [IDX_W-1:0]        best_r, best_nxt;
  logic [TIME_W-1:0]       best_due_r, best_due_nxt;
  logic [ID_W-1:0]         best_id_r, best_id_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_data_r, out_data_nxt;

  // Entry storage, one read port addressed by the sequencer.
  logic [ID_W-1:0]         id_r    [MAX_TIMERS];
  logic [TIME_W-1:0]       due_r   [MAX_TIMERS];
  logic [ID_W-1:0]         per_r   [MAX_TIMERS];
  logic [ID_W-1:0]         fires_r [MAX_TIMERS];

  logic [IDX_W-1:0]        rd_idx;
  logic [ID_W-1:0]         e_id, e_per, e_fires, fires_new;
  logic [TIME_W-1:0]       e_due, b_due;
  cmp_res_t                cmp;

  logic [IDX_W-1:0]        free_idx;
  logic                    full;
  logic                    out_free;
  logic                    wr_add, wr_emit;
  logic [MAX_TIMERS-1:0]   pend_left;

  assign rd_idx  = (state_r == S_EMIT) ? best_r : idx_r;
  assign e_id    = id_r[rd_idx];
  assign e_due   = due_r[rd_idx];
  assign e_per   = per_r[rd_idx];
  assign e_fires = fires_r[rd_idx];
  assign b_due   = (state_r == S_SCAN) ? now_r : best_due_r;

  mts_cmp u_cmp (
    .a_due (e_due),
    .a_id  (e_id),
    .b_due (b_due),
    .b_id  (best_id_r),
    .res   (cmp)
  );

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IDX_W'(i);
    end
  end
  assign full = &valid_r;

  assign out_free  = !out_valid_r || out_ready;
  assign fires_new = (e_fires == '1) ? e_fires : e_fires + ID_W'(1);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    nid_nxt       = nid_r;
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_due_nxt  = best_due_r;
    best_id_nxt   = best_id_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_add        = 1'b0;
    wr_emit       = 1'b0;
    pend_left     = pend_r;
    pend_left[best_r] = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          idx_nxt = '0;
          unique case (opcode_t'(in_data.opcode))
            OP_ADD:    state_nxt = S_ADD;
            OP_CANCEL: state_nxt = S_CANCEL;
            OP_CLEAR:  state_nxt = S_CLEAR;
            OP_TICK: begin
              now_nxt   = now_r + TIME_W'(1);
              state_nxt = S_SCAN;
            end
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (full) begin
            out_data_nxt = '{kind: KIND_FULL, timer_id: '0, fire_count: '0, last: 1'b1};
          end else begin
            wr_add              = 1'b1;
            valid_nxt[free_idx] = 1'b1;
            out_data_nxt = '{kind: KIND_ADDED, timer_id: nid_r, fire_count: '0, last: 1'b1};
            nid_nxt = (nid_r == '1) ? ID_W'(1) : nid_r + ID_W'(1);
          end
        end
      end
      S_CANCEL: begin
        // Stop at the lowest slot that matches.
        if (valid_r[idx_r] && (e_id == req_r.cancel_id)) begin
          valid_nxt[idx_r] = 1'b0;
          state_nxt        = S_IDLE;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_CLEAR: begin
        valid_nxt = '0;
        nid_nxt   = ID_W'(1);
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        // Snapshot which entries are due at the new time.
        pend_nxt[idx_r] = valid_r[idx_r] && (cmp.due_lt || cmp.due_eq);
        found_nxt       = 1'b0;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_FIND;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_FIND: begin
        // Strict less-than keeps the lower slot on equal keys.
        if (pend_r[idx_r] && (!found_r || cmp.key_lt)) begin
          found_nxt    = 1'b1;
          best_nxt     = idx_r;
          best_due_nxt = e_due;
          best_id_nxt  = e_id;
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = found_nxt ? S_EMIT : S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          wr_emit        = 1'b1;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '{kind: KIND_FIRED, timer_id: e_id, fire_count: fires_new,
                             last: (pend_left == '0)};
          pend_nxt       = pend_left;
          if (e_per == '0) valid_nxt[best_r] = 1'b0;
          found_nxt      = 1'b0;
          idx_nxt        = '0;
          state_nxt      = (pend_left == '0) ? S_IDLE : S_FIND;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      nid_r       <= ID_W'(1);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
      found_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      nid_r       <= nid_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    best_r     <= best_nxt;
    best_due_r <= best_due_nxt;
    best_id_r  <= best_id_nxt;
    out_data_r <= out_data_nxt;
  end

  // Entry writes: a new timer, or the update of a fired one.
  always_ff @(posedge clk) begin
    if (wr_add) begin
      id_r[free_idx]    <= nid_r;
      due_r[free_idx]   <= now_r + TIME_W'(req_r.delay_ms);
      per_r[free_idx]   <= req_r.interval_ms;
      fires_r[free_idx] <= '0;
    end else if (wr_emit) begin
      due_r[best_r]   <= e_due + TIME_W'(e_per);
      fires_r[best_r] <= fires_new;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hw/rtl/mts_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "multi_timer_scheduler_defines.svh"

module mts_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire mts_pkg::out_t out_data
);
  import mts_pkg::*;

  // A stalled result holds its value.
  `MTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // The block is not ready in the cycle after it takes a transaction.
  `MTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

  // Add and full results are single and carry no fire count.
  `MTS_ASSERT_IMP(a_add_single, out_valid && (out_data.kind != KIND_FIRED), out_data.last && (out_data.fire_count == '0), "add result malformed")

  // An assigned identifier is never zero.
  `MTS_ASSERT_IMP(a_id_nonzero, out_valid && (out_data.kind == KIND_ADDED), out_data.timer_id != '0, "zero identifier assigned")

endmodule

bind multi_timer_scheduler mts_checker u_mts_checker (.*);

`default_nettype wire

/* sim/tb_multi_timer_scheduler.sv */
`timescale 1ns / 1ps

module tb_multi_timer_scheduler;
  import mts_pkg::*;

  localparam int NSLOT = MAX_TIMERS;
  localparam int SETTLE_CYCLES = 40 * NSLOT;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  multi_timer_scheduler DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Free-running clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the timer table.
  logic [47:0] now_ms;
  logic [31:0] id_next;
  bit          slot_busy [NSLOT];
  logic [31:0] slot_id [NSLOT];
  logic [47:0] slot_due [NSLOT];
  logic [31:0] slot_period [NSLOT];
  logic [31:0] slot_fires [NSLOT];

  out_t pending_results[$];
  int   errors;
  int   send_idle_pct;
  int   recv_stall_pct;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic void reset_table();
    now_ms = '0;
    id_next = 32'd1;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
  endfunction

  // True when slot a fires ahead of slot b: by due time, then id, then slot.
  function automatic bit fires_ahead(int a, int b);
    if (slot_due[a] != slot_due[b]) return slot_due[a] < slot_due[b];
    if (slot_id[a] != slot_id[b]) return slot_id[a] < slot_id[b];
    return a < b;
  endfunction

  // Update the shadow table for one transaction and return the results it causes.
  function automatic void schedule_step(input in_t it, ref out_t res[$]);
    int   order [NSLOT];
    int   n;
    int   j;
    int   s;
    int   free_slot;
    out_t r;
    res.delete();
    case (opcode_t'(it.opcode))
      OP_ADD: begin
        free_slot = -1;
        for (int i = NSLOT - 1; i >= 0; i--) if (!slot_busy[i]) free_slot = i;
        r = '0;
        r.last = 1'b1;
        if (free_slot < 0) begin
          r.kind = KIND_FULL;
        end else begin
          slot_busy[free_slot] = 1'b1;
          slot_id[free_slot] = id_next;
          slot_due[free_slot] = now_ms + {16'd0, it.delay_ms};
          slot_period[free_slot] = it.interval_ms;
          slot_fires[free_slot] = '0;
          r.kind = KIND_ADDED;
          r.timer_id = id_next;
          id_next = (id_next == 32'hFFFF_FFFF) ? 32'd1 : id_next + 32'd1;
        end
        res = {res, r};
      end
      OP_CANCEL: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_busy[i] && slot_id[i] == it.cancel_id) begin
            slot_busy[i] = 1'b0;
            break;
          end
        end
      end
      OP_CLEAR: begin
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        id_next = 32'd1;
      end
      default: begin
        // Tick: collect due timers in firing order, then fire each once.
        now_ms = now_ms + 48'd1;
        n = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_busy[i] && slot_due[i] <= now_ms) begin
            j = n;
            while (j > 0 && fires_ahead(i, order[j - 1])) begin
              order[j] = order[j - 1];
              j--;
            end
            order[j] = i;
            n++;
          end
        end
        for (int k = 0; k < n; k++) begin
          s = order[k];
          if (slot_fires[s] != 32'hFFFF_FFFF) slot_fires[s] = slot_fires[s] + 32'd1;
          r.kind = KIND_FIRED;
          r.timer_id = slot_id[s];
          r.fire_count = slot_fires[s];
          r.last = (k == n - 1);
          res = {res, r};
          if (slot_period[s] != 0) slot_due[s] = slot_due[s] + {16'd0, slot_period[s]};
          else slot_busy[s] = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic in_t make_item(opcode_t op, logic [31:0] d, logic [31:0] iv,
                                    logic [31:0] cid);
    in_t it;
    it.opcode = op;
    it.delay_ms = d;
    it.interval_ms = iv;
    it.cancel_id = cid;
    return it;
  endfunction

  function automatic void add_row(in_t it, bit typed, kind_t k, logic [31:0] id,
                                  logic [31:0] cnt);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.want.kind = k;
    row.want.timer_id = id;
    row.want.fire_count = cnt;
    row.want.last = 1'b1;
    directed = {directed, row};
  endfunction

  // Present one transaction, wait for acceptance and record what it should produce.
  task automatic send_item(in_t it, bit typed, out_t want);
    out_t res[$];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    schedule_step(it, res);
    if (typed) pending_results = {pending_results, want};
    else foreach (res[i]) pending_results = {pending_results, res[i]};
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic in_t random_item();
    in_t         it;
    int          pick;
    int          live [$];
    it.delay_ms = $urandom();
    it.interval_ms = $urandom();
    it.cancel_id = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 38) it.opcode = OP_ADD;
    else if (pick < 55) it.opcode = OP_CANCEL;
    else if (pick < 97) it.opcode = OP_TICK;
    else it.opcode = OP_CLEAR;
    // Mostly short delays and periods so timers actually fire.
    if ($urandom_range(0, 9) < 8) it.delay_ms = $urandom_range(0, 12);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.interval_ms = '0;
      4, 5, 6, 7, 8: it.interval_ms = $urandom_range(1, 6);
      default: ;
    endcase
    if (it.opcode == OP_CANCEL && $urandom_range(0, 9) < 7) begin
      for (int i = 0; i < NSLOT; i++) if (slot_busy[i]) live = {live, int'(slot_id[i])};
      if (live.size() > 0) it.cancel_id = live[$urandom_range(0, live.size() - 1)];
    end
    return it;
  endfunction

  // Receiver stalls at the rate of the current phase.
  always @(negedge clk) begin
    if (rst_n) begin
      out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d id %0d", out_data.kind, out_data.timer_id);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.kind !== exp_r.kind) begin
          $error("kind: expected %0d, actual %0d", exp_r.kind, out_data.kind);
          errors++;
        end
        if (out_data.timer_id !== exp_r.timer_id) begin
          $error("timer_id: expected %0d, actual %0d", exp_r.timer_id, out_data.timer_id);
          errors++;
        end
        if (out_data.fire_count !== exp_r.fire_count) begin
          $error("fire_count: expected %0d, actual %0d", exp_r.fire_count,
                 out_data.fire_count);
          errors++;
        end
        if (out_data.last !== exp_r.last) begin
          $error("last: expected %0d, actual %0d", exp_r.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then four phases of random traffic with varied idling and stalls.
  initial begin
    int wait_cycles;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    reset_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_row(make_item(OP_ADD, 32'd0, 32'd0, 32'hFFFF_FFFF), 1, KIND_ADDED, 32'd1, 32'd0);
    add_row(make_item(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0), 1, KIND_FIRED, 32'd1,
            32'd1);
    add_row(make_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0), 1, KIND_ADDED, 32'd2,
            32'd0);
    add_row(make_item(OP_ADD, 32'd3, 32'd0, 32'd0), 1, KIND_ADDED, 32'd3, 32'd0);
    add_row(make_item(OP_CANCEL, 32'd0, 32'd0, 32'd2), 0, KIND_ADDED, 0, 0);
    add_row(make_item(OP_CANCEL, 32'd0, 32'd0, 32'hFFFF_FFFF), 0, KIND_ADDED, 0, 0);
    add_row(make_item(OP_TICK, 32'd0, 32'd0, 32'd0), 0, KIND_ADDED, 0, 0);
    add_row(make_item(OP_TICK, 32'd0, 32'd0, 32'd0), 0, KIND_ADDED, 0, 0);
    add_row(make_item(OP_TICK, 32'd0, 32'd0, 32'd0), 1, KIND_FIRED, 32'd3, 32'd1);
    add_row(make_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0,
            KIND_ADDED, 0, 0);
    // Fill every slot with a due periodic timer, then overflow the table.
    for (int i = 0; i < NSLOT; i++)
      add_row(make_item(OP_ADD, 32'd0, 32'd1, 32'd0), 0, KIND_ADDED, 0, 0);
    add_row(make_item(OP_ADD, 32'd5, 32'd5, 32'd0), 1, KIND_FULL, 32'd0, 32'd0);
    add_row(make_item(OP_TICK, 32'd0, 32'd0, 32'd0), 0, KIND_ADDED, 0, 0);
    add_row(make_item(OP_CLEAR, 32'd0, 32'd0, 32'd0), 0, KIND_ADDED, 0, 0);

    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 45 : (phase == 3) ? 36 : 0;
      recv_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 36 : 0;
      for (int n = 0; n < 58; n++) send_item(random_item(), 0, '0);
      // Hold the sender until the block has drained.
      if (phase == 1) wait (pending_results.size() == 0);
    end

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_multi_timer_scheduler passed");
    end else begin
      $display("tb_multi_timer_scheduler failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("tb_multi_timer_scheduler failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mts_pkg.sv
hw/rtl/mts_cmp.sv
hw/rtl/multi_timer_scheduler.sv
hw/rtl/mts_checker.sv
sim/tb_multi_timer_scheduler.sv
